// File: rtl/hhtd_pkg.sv
// shared types and constants for the heap-indexed huffman tree decoder
// no dependencies
`timescale 1ns / 1ps

package hhtd_pkg;

  localparam int TABLE_BITS       = 12;
  localparam int ADDR_W           = TABLE_BITS + 1;
  localparam int DEPTH_W          = 4;
  localparam int SYM_W            = 8;
  localparam int LEN_W            = 4;
  localparam int IN_DATA_W        = 32;
  localparam int OUT_DATA_W       = 8;
  localparam int MAX_CODE_LEN_DEF = 12;

  localparam logic [ADDR_W-1:0] ROOT_INDEX = ADDR_W'(1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load_wr;
    logic lookup_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic result;
    logic out_blocked;
  } sts_t;

endpackage

// File: rtl/hhtd_ctrl.sv
// controller state machine: table clearing, loads and decode lookups
// depends on hhtd_pkg
`timescale 1ns / 1ps

module hhtd_ctrl
  import hhtd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_op,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_op == OP_DECODE) begin
            cmd.lookup_start = 1'b1;
            state_next       = ST_LOOKUP;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        if (!sts.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/hhtd_datapath.sv
// datapath: symbol table memory, cursor, depth counter and output register
// depends on hhtd_pkg
`timescale 1ns / 1ps

module hhtd_datapath
  import hhtd_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [SYM_W-1:0]      symbol_in,
  input  logic [TABLE_BITS-1:0] code_word,
  input  logic [LEN_W-1:0]      code_len,
  input  logic                  code_bit,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SYM_W-1:0]      m_tdata,
  output logic                  m_tuser
);

  localparam int LIMIT_INT = (MAX_CODE_LEN > TABLE_BITS) ? TABLE_BITS :
                             ((MAX_CODE_LEN < 1) ? 1 : MAX_CODE_LEN);
  localparam logic [DEPTH_W-1:0] LIMIT = DEPTH_W'(LIMIT_INT);

  logic [SYM_W-1:0]   mem [2**ADDR_W];
  logic [SYM_W-1:0]   rdata;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  cursor;
  logic [DEPTH_W-1:0] depth;
  logic [ADDR_W-1:0]  lookup_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  load_mask;
  logic [ADDR_W-1:0]  load_addr;
  logic               load_ok;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SYM_W-1:0]   wr_data;
  logic [DEPTH_W-1:0] depth_next;
  logic               leaf;
  logic               at_limit;

  // heap index of a load entry
  assign load_ok   = (code_len != '0) && (code_len <= LEN_W'(TABLE_BITS));
  assign load_mask = (ADDR_W'(1) << code_len) - ADDR_W'(1);
  assign load_addr = (ADDR_W'(1) << code_len) | ({1'b0, code_word} & load_mask);

  assign wr_en   = cmd.clear_step || (cmd.load_wr && load_ok);
  assign wr_addr = cmd.clear_step ? clr_addr : load_addr;
  assign wr_data = cmd.clear_step ? '0 : symbol_in;

  assign rd_addr = cmd.lookup_start ? {cursor[ADDR_W-2:0], code_bit} : lookup_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_start) begin
      lookup_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign depth_next = depth + DEPTH_W'(1);
  assign leaf       = (rdata != '0);
  assign at_limit   = (depth_next >= LIMIT);

  assign sts.clr_last    = (clr_addr == '1);
  assign sts.result      = leaf || at_limit;
  assign sts.out_blocked = sts.result && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= ROOT_INDEX;
      depth  <= '0;
    end else if (cmd.commit) begin
      if (sts.result) begin
        cursor <= ROOT_INDEX;
        depth  <= '0;
      end else begin
        cursor <= lookup_addr;
        depth  <= depth_next;
      end
    end
  end

  // output register, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit && sts.result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && sts.result) begin
      m_tdata <= leaf ? rdata : '0;
      m_tuser <= !leaf;
    end
  end

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("overflow result with non-zero symbol");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth < LIMIT)
    else $error("cursor depth at or beyond limit");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && sts.result |=> m_tvalid)
    else $error("result lost at commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && sts.result |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");

endmodule

// File: rtl/huffman_heap_tree_decoder_core.sv
// top level of the heap-indexed huffman tree decoder
// depends on hhtd_pkg, hhtd_ctrl and hhtd_datapath
// channel | dir | signals                          | payload
// s_axis  | in  | s_tvalid s_tready s_tdata s_tuser | load entry or one code bit
// m_axis  | out | m_tvalid m_tready m_tdata m_tuser | decoded symbol or overflow
// after reset all 8192 table entries are cleared one entry a cycle, no input taken
// a load item is written as it is taken; a decode bit reads the table at the new cursor
// one result is held in the output register; a new item is taken while it waits
// a decode step that produces a result waits only while that register is full
`timescale 1ns / 1ps

module huffman_heap_tree_decoder_core
  import hhtd_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // symbol_in[7:0] code_word[19:8] code_len[23:20] code_bit[24]
  input  logic                  s_tuser,  // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // symbol_out[7:0]
  output logic                  m_tuser   // overflow
);

  cmd_t cmd;
  sts_t sts;

  hhtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hhtd_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .symbol_in (s_tdata[7:0]),
    .code_word (s_tdata[19:8]),
    .code_len  (s_tdata[23:20]),
    .code_bit  (s_tdata[24]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: tb/tb_huffman_heap_tree_decoder_core.sv
// testbench for huffman_heap_tree_decoder_core: loads code words into the heap table,
// streams code bits and checks every decoded symbol against its own tree walk
// depends on hhtd_pkg and the rtl of huffman_heap_tree_decoder_core
`timescale 1ns / 1ps

module tb_huffman_heap_tree_decoder_core;
  import hhtd_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int RANDOM_ITEMS = 875;
  localparam int DEPTH_LIMIT = (MAX_CODE_LEN_DEF > TABLE_BITS) ? TABLE_BITS :
                               ((MAX_CODE_LEN_DEF < 1) ? 1 : MAX_CODE_LEN_DEF);

  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] sym;
    logic [11:0]      word;
    logic [LEN_W-1:0] len;
    logic             code_bit;
  } stream_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             overflow;
  } decoded_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // symbol_in[7:0] code_word[19:8] code_len[23:20] code_bit[24]
  logic                  s_tuser = 1'b0; // op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // symbol_out[7:0]
  logic                  m_tuser;        // overflow

  stream_item_t     stream_q[$];
  decoded_t         decoded_q[$];
  logic [SYM_W-1:0] sym_table [1 << ADDR_W];
  logic [ADDR_W-1:0] cursor;
  stream_item_t     drv_item;
  logic             in_taken = 1'b0;
  int unsigned      accepted_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      error_count = 0;
  int unsigned      hold_left = 0;
  logic             hold_done = 1'b0;

  huffman_heap_tree_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 50) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic int heap_depth(input logic [ADDR_W-1:0] idx);
    int d;
    d = 0;
    while (idx > 1) begin
      idx = idx >> 1;
      d++;
    end
    return d;
  endfunction

  // walk the tree one accepted transfer at a time
  function automatic void tree_walk(input logic op, input logic [IN_DATA_W-1:0] data);
    logic [SYM_W-1:0]  sym;
    logic [11:0]       word;
    logic [LEN_W-1:0]  len;
    logic              code_bit;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] nxt;
    decoded_t          res;
    sym      = data[7:0];
    word     = data[19:8];
    len      = data[23:20];
    code_bit = data[24];
    if (op == OP_LOAD) begin
      if (len >= 1 && len <= TABLE_BITS) begin
        mask = (ADDR_W'(1) << len) - ADDR_W'(1);
        sym_table[(ADDR_W'(1) << len) | ({1'b0, word} & mask)] = sym;
      end
    end else begin
      if (cursor == '0 || heap_depth(cursor) >= DEPTH_LIMIT) cursor = ROOT_INDEX;
      nxt = {cursor[ADDR_W-2:0], code_bit};
      if (sym_table[nxt] != '0) begin
        res.symbol   = sym_table[nxt];
        res.overflow = 1'b0;
        decoded_q.push_back(res);
        cursor = ROOT_INDEX;
      end else if (heap_depth(nxt) >= DEPTH_LIMIT) begin
        res.symbol   = '0;
        res.overflow = 1'b1;
        decoded_q.push_back(res);
        cursor = ROOT_INDEX;
      end else begin
        cursor = nxt;
      end
    end
  endfunction

  task automatic check_decoded(input logic [SYM_W-1:0] symbol, input logic overflow);
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer symbol %02h overflow %0b", symbol, overflow));
    end else begin
      want = decoded_q.pop_front();
      if (symbol !== want.symbol) begin
        report_mismatch($sformatf("symbol %02h, want %02h", symbol, want.symbol));
      end
      if (overflow !== want.overflow) begin
        report_mismatch($sformatf("overflow %0b, want %0b", overflow, want.overflow));
      end
    end
  endtask

  function automatic void push_load(input logic [SYM_W-1:0] sym, input logic [11:0] word,
                                    input logic [LEN_W-1:0] len);
    stream_item_t it;
    it.op       = OP_LOAD;
    it.sym      = sym;
    it.word     = word;
    it.len      = len;
    it.code_bit = 1'($urandom_range(1));
    stream_q.push_back(it);
  endfunction

  function automatic void push_decode(input logic code_bit);
    stream_item_t it;
    it.op       = OP_DECODE;
    it.sym      = 8'($urandom_range(255));
    it.word     = 12'($urandom_range(4095));
    it.len      = 4'($urandom_range(15));
    it.code_bit = code_bit;
    stream_q.push_back(it);
  endfunction

  function automatic int tx_idle_pct();
    if (accepted_count < 300) return 21;
    if (accepted_count < 600) return 52;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (accepted_count < 300) return 52;
    if (accepted_count < 600) return 21;
    return 0;
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
          drv_item = stream_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, drv_item.code_bit, drv_item.len, drv_item.word, drv_item.sym};
          s_tuser  <= drv_item.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // long receiver hold-off so the output register fills and the input stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_count >= 650) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) check_decoded(m_tdata, m_tuser);
      if (s_tvalid && s_tready) begin
        accepted_count <= accepted_count + 1;
        tree_walk(s_tuser, s_tdata);
      end
    end
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("[huffman_heap_tree_decoder_core] ERROR");
    $finish;
  end

  initial begin
    logic [11:0]      code_words[$];
    logic [LEN_W-1:0] code_lens[$];
    logic [11:0]      word;
    logic [LEN_W-1:0] len;
    stream_item_t     it;
    int               rand_items;
    int               total_items;
    int               sel;
    int               k;
    int               n;
    int               j;

    foreach (sym_table[i]) sym_table[i] = '0;
    cursor = ROOT_INDEX;

    // directed part
    push_load(8'hA5, 12'hFFE, 4'd1);   // bits above the length are dropped
    push_load(8'hFF, 12'hFFF, 4'd12);
    push_load(8'h01, 12'h002, 4'd2);
    push_load(8'h77, 12'h000, 4'd0);   // length zero, ignored
    push_load(8'h66, 12'hFFF, 4'd15);  // too long, ignored
    push_decode(1'b0);
    push_decode(1'b1);
    push_decode(1'b0);
    for (j = 0; j < 12; j++) push_decode(1'b1);
    for (j = 0; j < 6; j++) push_decode(1'b1);
    push_load(8'h00, 12'hFFF, 4'd12);  // entry emptied mid-walk, cursor kept
    for (j = 0; j < 6; j++) push_decode(1'b1);

    // random part: mostly walks of loaded code words
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 15 || code_words.size() == 0) begin
        len  = ($urandom_range(3) != 0) ? 4'($urandom_range(4, 1)) : 4'($urandom_range(12, 5));
        word = 12'($urandom_range(4095)) & 12'((1 << len) - 1);
        push_load(8'($urandom_range(255, 1)), 12'(word | ($urandom << len)), len);
        if (code_words.size() < 16) begin
          code_words.push_back(word);
          code_lens.push_back(len);
        end else begin
          k = $urandom_range(15);
          code_words[k] = word;
          code_lens[k]  = len;
        end
        rand_items++;
      end else if (sel < 20) begin
        k = $urandom_range(code_words.size() - 1);
        push_load(8'h00, code_words[k], code_lens[k]);
        rand_items++;
      end else if (sel < 75) begin
        k = $urandom_range(code_words.size() - 1);
        for (j = code_lens[k] - 1; j >= 0; j--) push_decode(code_words[k][j]);
        rand_items += code_lens[k];
      end else if (sel < 85) begin
        // broken walk: the leading bits of a code word, from one bit up to all of them
        k = $urandom_range(code_words.size() - 1);
        n = $urandom_range(code_lens[k], 1);
        for (j = code_lens[k] - 1; j >= int'(code_lens[k]) - n; j--) begin
          push_decode(code_words[k][j]);
        end
        rand_items += n;
      end else begin
        it.op       = 1'($urandom_range(1));
        it.sym      = 8'($urandom_range(255));
        it.word     = 12'($urandom_range(4095));
        it.len      = 4'($urandom_range(15));
        it.code_bit = 1'($urandom_range(1));
        stream_q.push_back(it);
        if (it.op == OP_DECODE || (it.len >= 1 && it.len <= TABLE_BITS)) rand_items++;
      end
    end
    total_items = stream_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("[huffman_heap_tree_decoder_core] OK");
    end else begin
      $display("[huffman_heap_tree_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
